// ===== hdl/bdd_ut_pkg.sv =====
`default_nettype none

package bdd_ut_pkg;

    // table geometry
    localparam int NODE_CAPACITY = 1024;
    localparam int VAR_COUNT     = 256;
    localparam int ID_W          = $clog2(NODE_CAPACITY);
    localparam int COUNT_W       = ID_W + 1;

    // fixed field widths
    localparam int VAR_W   = 8;
    localparam int CHILD_W = 11;
    localparam logic [CHILD_W-1:0] NULL_CHILD = 11'd1024;

    // hash index: one bucket head per node slot
    localparam int BUCKET_COUNT = NODE_CAPACITY;
    localparam int BUCKET_W     = $clog2(BUCKET_COUNT);
    localparam int KEY_W        = VAR_W + 2 * CHILD_W;
    localparam int KEY_CHUNKS   = (KEY_W + BUCKET_W - 1) / BUCKET_W;
    localparam int KEY_PAD_W    = KEY_CHUNKS * BUCKET_W;

    // terminal node ids
    localparam logic [ID_W-1:0] TERM_ZERO_ID = ID_W'(0);
    localparam logic [ID_W-1:0] TERM_ONE_ID  = ID_W'(1);
    localparam logic [VAR_W-1:0] TERM_ZERO_VAR = VAR_W'(0);
    localparam logic [VAR_W-1:0] TERM_ONE_VAR  = VAR_W'(1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_DIRECT,
        KIND_SEARCH
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [ID_W-1:0]      direct_id;
        logic [VAR_W-1:0]     var_idx;
        logic [CHILD_W-1:0]   high;
        logic [CHILD_W-1:0]   low;
        logic [BUCKET_W-1:0]  bucket;
    } queue_item_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } link_t;

    typedef struct packed {
        link_t              next;
        logic [VAR_W-1:0]   var_idx;
        logic [CHILD_W-1:0] high;
        logic [CHILD_W-1:0] low;
    } node_word_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_NODE
    } state_t;

    // xor fold of the node triple onto a bucket number
    function automatic logic [BUCKET_W-1:0] bucket_of(
        input logic [VAR_W-1:0]   var_idx,
        input logic [CHILD_W-1:0] high,
        input logic [CHILD_W-1:0] low
    );
        logic [KEY_PAD_W-1:0] key;
        logic [BUCKET_W-1:0]  h;
        key = KEY_PAD_W'({var_idx, high, low});
        h   = '0;
        for (int i = 0; i < KEY_CHUNKS; i++)
        begin
            h = h ^ key[i*BUCKET_W +: BUCKET_W];
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bdd_unique_node_table_core.sv =====
`default_nettype none

// Find-or-add unique table for decision diagram nodes. Raise start with a
// (var_index, high_child, low_child) triple; it is taken on a clock edge where
// busy is low. Each item gives exactly one result, shown on node_id, was_added
// and table_full for a single cycle while done is high; results come in item
// order and cannot be held off, so the receiver must take them as they come.
// After reset the block sweeps its 1024-entry bucket head memory, one entry a
// cycle, and holds busy high until the sweep is done. Items pass a registered
// classify stage and a two-entry queue. Reduced, terminal and out-of-range
// items are then answered by the back end straight from its idle state. All
// others read the bucket head and then one node per link along the hash chain
// (one read of the synchronous node memory per link) until a match or the end;
// an append needs no extra step. The back end handles one item at a time.
module bdd_unique_node_table_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [bdd_ut_pkg::VAR_W-1:0]    var_index,
    input  wire logic [bdd_ut_pkg::CHILD_W-1:0]  high_child,
    input  wire logic [bdd_ut_pkg::CHILD_W-1:0]  low_child,
    output logic                                 done,
    output logic [bdd_ut_pkg::ID_W-1:0]          node_id,
    output logic                                 was_added,
    output logic                                 table_full
);

    logic                    clear_busy;
    logic                    q_full;
    logic                    q_empty;
    logic                    push;
    logic                    pop;
    bdd_ut_pkg::queue_item_t push_item;
    bdd_ut_pkg::queue_item_t q_head;

    // accept and classify
    bdd_ut_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .var_index  (var_index),
        .high_child (high_child),
        .low_child  (low_child),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .busy       (busy),
        .push       (push),
        .push_item  (push_item)
    );

    // item queue
    bdd_ut_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_item (q_head)
    );

    // hash chain walk and append
    bdd_ut_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (pop),
        .clear_busy (clear_busy),
        .done       (done),
        .node_id    (node_id),
        .was_added  (was_added),
        .table_full (table_full)
    );

endmodule

`default_nettype wire

// ===== hdl/bdd_ut_ram.sv =====
`default_nettype none

module bdd_ut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/bdd_ut_front.sv =====
`default_nettype none

module bdd_ut_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [bdd_ut_pkg::VAR_W-1:0]       var_index,
    input  wire logic [bdd_ut_pkg::CHILD_W-1:0]     high_child,
    input  wire logic [bdd_ut_pkg::CHILD_W-1:0]     low_child,
    input  wire logic                               clear_busy,
    input  wire logic                               q_full,
    output logic                                    busy,
    output logic                                    push,
    output bdd_ut_pkg::queue_item_t                 push_item
);

    logic                    stage_valid_reg;
    logic                    stage_valid_next;
    bdd_ut_pkg::queue_item_t stage_item_reg;
    bdd_ut_pkg::queue_item_t stage_item_next;
    bdd_ut_pkg::queue_item_t classified;
    logic                    accept;

    // stage may reload in the same cycle it drains into the queue
    assign busy   = clear_busy || (stage_valid_reg && q_full);
    assign accept = start && !busy;
    assign push   = stage_valid_reg && !q_full;
    assign push_item = stage_item_reg;

    // classify: out of range, reduced, terminal or search
    always_comb
    begin
        classified.kind      = bdd_ut_pkg::KIND_SEARCH;
        classified.direct_id = '0;
        classified.var_idx   = var_index;
        classified.high      = high_child;
        classified.low       = low_child;
        classified.bucket    = bdd_ut_pkg::bucket_of(var_index, high_child, low_child);
        priority if (32'(var_index) >= bdd_ut_pkg::VAR_COUNT)
        begin
            classified.kind = bdd_ut_pkg::KIND_DIRECT;
        end
        else if (var_index != bdd_ut_pkg::TERM_ZERO_VAR &&
                 var_index != bdd_ut_pkg::TERM_ONE_VAR && high_child == low_child)
        begin
            classified.kind      = bdd_ut_pkg::KIND_DIRECT;
            classified.direct_id = high_child[bdd_ut_pkg::ID_W-1:0];
        end
        else if (var_index == bdd_ut_pkg::TERM_ZERO_VAR &&
                 high_child == bdd_ut_pkg::NULL_CHILD &&
                 low_child == bdd_ut_pkg::NULL_CHILD)
        begin
            classified.kind      = bdd_ut_pkg::KIND_DIRECT;
            classified.direct_id = bdd_ut_pkg::TERM_ZERO_ID;
        end
        else if (var_index == bdd_ut_pkg::TERM_ONE_VAR &&
                 high_child == bdd_ut_pkg::NULL_CHILD &&
                 low_child == bdd_ut_pkg::NULL_CHILD)
        begin
            classified.kind      = bdd_ut_pkg::KIND_DIRECT;
            classified.direct_id = bdd_ut_pkg::TERM_ONE_ID;
        end
        else
        begin
            classified.kind = bdd_ut_pkg::KIND_SEARCH;
        end
    end

    // stage next value
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
            stage_item_next  = classified;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
    end

endmodule

`default_nettype wire

// ===== hdl/bdd_ut_fifo.sv =====
`default_nettype none

module bdd_ut_fifo (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire bdd_ut_pkg::queue_item_t push_item,
    input  wire logic                    pop,
    output logic                         full,
    output logic                         empty,
    output bdd_ut_pkg::queue_item_t      head_item
);

    bdd_ut_pkg::queue_item_t                entry_reg [bdd_ut_pkg::QUEUE_DEPTH];
    logic [bdd_ut_pkg::QPTR_W-1:0]          wr_ptr_reg;
    logic [bdd_ut_pkg::QPTR_W-1:0]          wr_ptr_next;
    logic [bdd_ut_pkg::QPTR_W-1:0]          rd_ptr_reg;
    logic [bdd_ut_pkg::QPTR_W-1:0]          rd_ptr_next;
    logic [bdd_ut_pkg::QCOUNT_W-1:0]        count_reg;
    logic [bdd_ut_pkg::QCOUNT_W-1:0]        count_next;
    logic                                   do_push;
    logic                                   do_pop;

    assign full      = count_reg == bdd_ut_pkg::QCOUNT_W'(bdd_ut_pkg::QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    // pointer and fill count update, depth is a power of two
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + bdd_ut_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + bdd_ut_pkg::QPTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + bdd_ut_pkg::QCOUNT_W'(1);
            2'b01:   count_next = count_reg - bdd_ut_pkg::QCOUNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bdd_ut_back.sv =====
`default_nettype none

module bdd_ut_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_empty,
    input  wire bdd_ut_pkg::queue_item_t         q_head,
    output logic                                 pop,
    output logic                                 clear_busy,
    output logic                                 done,
    output logic [bdd_ut_pkg::ID_W-1:0]          node_id,
    output logic                                 was_added,
    output logic                                 table_full
);

    localparam int NODE_WORD_W = $bits(bdd_ut_pkg::node_word_t);
    localparam int LINK_W      = $bits(bdd_ut_pkg::link_t);

    bdd_ut_pkg::state_t                    state_reg;
    bdd_ut_pkg::state_t                    state_next;
    bdd_ut_pkg::queue_item_t               item_reg;
    bdd_ut_pkg::queue_item_t               item_next;
    bdd_ut_pkg::link_t                     head_link_reg;
    bdd_ut_pkg::link_t                     head_link_next;
    logic [bdd_ut_pkg::ID_W-1:0]           cur_id_reg;
    logic [bdd_ut_pkg::ID_W-1:0]           cur_id_next;
    logic [bdd_ut_pkg::COUNT_W-1:0]        used_count_reg;
    logic [bdd_ut_pkg::COUNT_W-1:0]        used_count_next;
    logic [bdd_ut_pkg::BUCKET_W-1:0]       clear_addr_reg;
    logic [bdd_ut_pkg::BUCKET_W-1:0]       clear_addr_next;

    logic                                  done_reg;
    logic                                  done_next;
    logic [bdd_ut_pkg::ID_W-1:0]           node_id_reg;
    logic [bdd_ut_pkg::ID_W-1:0]           node_id_next;
    logic                                  was_added_reg;
    logic                                  was_added_next;
    logic                                  table_full_reg;
    logic                                  table_full_next;

    logic                                  head_we;
    logic [bdd_ut_pkg::BUCKET_W-1:0]       head_waddr;
    bdd_ut_pkg::link_t                     head_wdata;
    logic [bdd_ut_pkg::BUCKET_W-1:0]       head_raddr;
    logic [LINK_W-1:0]                     head_rbits;
    bdd_ut_pkg::link_t                     head_rdata;

    logic                                  node_we;
    logic [bdd_ut_pkg::ID_W-1:0]           node_waddr;
    bdd_ut_pkg::node_word_t                node_wdata;
    logic [bdd_ut_pkg::ID_W-1:0]           node_raddr;
    logic [NODE_WORD_W-1:0]                node_rbits;
    bdd_ut_pkg::node_word_t                node_rdata;

    logic                                  node_match;
    logic                                  chain_end;
    logic                                  do_insert;
    logic                                  table_is_full;
    logic                                  clear_last;

    // bucket heads, cleared by the sweep after reset
    bdd_ut_ram #(
        .WIDTH (LINK_W),
        .DEPTH (bdd_ut_pkg::BUCKET_COUNT)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rbits)
    );

    // node triples with chain links, read only below the fill count
    bdd_ut_ram #(
        .WIDTH (NODE_WORD_W),
        .DEPTH (bdd_ut_pkg::NODE_CAPACITY)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rbits)
    );

    assign head_rdata = head_rbits;
    assign node_rdata = node_rbits;

    // chain compare and status
    assign node_match = node_rdata.var_idx == item_reg.var_idx &&
                        node_rdata.high == item_reg.high &&
                        node_rdata.low == item_reg.low;
    assign chain_end     = !node_rdata.next.valid;
    assign table_is_full = used_count_reg >= bdd_ut_pkg::COUNT_W'(bdd_ut_pkg::NODE_CAPACITY);
    assign clear_last    = clear_addr_reg == bdd_ut_pkg::BUCKET_W'(bdd_ut_pkg::BUCKET_COUNT - 1);
    assign clear_busy    = state_reg == bdd_ut_pkg::ST_CLEAR;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdd_ut_pkg::ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = bdd_ut_pkg::ST_IDLE;
                end
            end
            bdd_ut_pkg::ST_IDLE:
            begin
                if (!q_empty && q_head.kind == bdd_ut_pkg::KIND_SEARCH)
                begin
                    state_next = bdd_ut_pkg::ST_HEAD;
                end
            end
            bdd_ut_pkg::ST_HEAD:
            begin
                state_next = head_rdata.valid ? bdd_ut_pkg::ST_NODE : bdd_ut_pkg::ST_IDLE;
            end
            bdd_ut_pkg::ST_NODE:
            begin
                if (node_match || chain_end)
                begin
                    state_next = bdd_ut_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdd_ut_pkg::ST_CLEAR;
            end
        endcase
    end

    // datapath, memory ports and result
    always_comb
    begin
        pop             = 1'b0;
        item_next       = item_reg;
        head_link_next  = head_link_reg;
        cur_id_next     = cur_id_reg;
        used_count_next = used_count_reg;
        clear_addr_next = clear_addr_reg;
        do_insert       = 1'b0;

        head_we         = 1'b0;
        head_waddr      = item_reg.bucket;
        head_wdata      = '0;
        head_raddr      = q_head.bucket;
        node_we         = 1'b0;
        node_waddr      = used_count_reg[bdd_ut_pkg::ID_W-1:0];
        node_wdata.next    = head_link_reg;
        node_wdata.var_idx = item_reg.var_idx;
        node_wdata.high    = item_reg.high;
        node_wdata.low     = item_reg.low;
        node_raddr      = head_rdata.id;

        done_next       = 1'b0;
        node_id_next    = node_id_reg;
        was_added_next  = was_added_reg;
        table_full_next = table_full_reg;

        unique case (state_reg)
            bdd_ut_pkg::ST_CLEAR:
            begin
                head_we         = 1'b1;
                head_waddr      = clear_addr_reg;
                clear_addr_next = clear_addr_reg + bdd_ut_pkg::BUCKET_W'(1);
            end
            bdd_ut_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    item_next = q_head;
                    if (q_head.kind == bdd_ut_pkg::KIND_DIRECT)
                    begin
                        done_next       = 1'b1;
                        node_id_next    = q_head.direct_id;
                        was_added_next  = 1'b0;
                        table_full_next = 1'b0;
                    end
                end
            end
            bdd_ut_pkg::ST_HEAD:
            begin
                head_link_next  = head_rdata;
                node_raddr      = head_rdata.id;
                cur_id_next     = head_rdata.id;
                // an empty bucket gives the new node an empty link
                node_wdata.next = head_rdata;
                do_insert       = !head_rdata.valid;
            end
            bdd_ut_pkg::ST_NODE:
            begin
                node_raddr  = node_rdata.next.id;
                cur_id_next = node_rdata.next.id;
                if (node_match)
                begin
                    done_next       = 1'b1;
                    node_id_next    = cur_id_reg;
                    was_added_next  = 1'b0;
                    table_full_next = 1'b0;
                end
                else
                begin
                    do_insert = chain_end;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase

        // append at the fill count and push onto the bucket chain, or flag a full table
        if (do_insert)
        begin
            done_next = 1'b1;
            if (table_is_full)
            begin
                node_id_next    = '0;
                was_added_next  = 1'b0;
                table_full_next = 1'b1;
            end
            else
            begin
                node_we          = 1'b1;
                head_we          = 1'b1;
                head_wdata.valid = 1'b1;
                head_wdata.id    = used_count_reg[bdd_ut_pkg::ID_W-1:0];
                node_id_next     = used_count_reg[bdd_ut_pkg::ID_W-1:0];
                was_added_next   = 1'b1;
                table_full_next  = 1'b0;
                used_count_next  = used_count_reg + bdd_ut_pkg::COUNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bdd_ut_pkg::ST_CLEAR;
            used_count_reg <= bdd_ut_pkg::COUNT_W'(2);
            clear_addr_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            clear_addr_reg <= clear_addr_next;
            done_reg       <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        head_link_reg  <= head_link_next;
        cur_id_reg     <= cur_id_next;
        node_id_reg    <= node_id_next;
        was_added_reg  <= was_added_next;
        table_full_reg <= table_full_next;
    end

    assign done       = done_reg;
    assign node_id    = node_id_reg;
    assign was_added  = was_added_reg;
    assign table_full = table_full_reg;

endmodule

`default_nettype wire

// ===== hdl/bdd_ut_checker.sv =====
`default_nettype none

module bdd_ut_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            busy,
    input wire logic                            done,
    input wire logic [bdd_ut_pkg::ID_W-1:0]     node_id,
    input wire logic                            was_added,
    input wire logic                            table_full
);

    // an append and a full table never come together
    a_added_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(was_added && table_full))
        else $error("was_added and table_full both set");

    // a full table reports id zero
    a_full_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> node_id == '0)
        else $error("table_full with non-zero node_id");

    // appended ids never reuse the terminal slots
    a_added_above_terminals: assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_added) |-> node_id > bdd_ut_pkg::ID_W'(1))
        else $error("appended node_id overlaps a terminal");

    // clearing sweep holds off items right after reset
    a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("busy low right after reset");

    // no result right after reset, while the sweep is still running
    a_no_done_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result right after reset");

endmodule

bind bdd_unique_node_table_core bdd_ut_checker u_bdd_ut_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .done       (done),
    .node_id    (node_id),
    .was_added  (was_added),
    .table_full (table_full)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

    typedef struct packed {
        logic [bdd_ut_pkg::ID_W-1:0] id;
        logic                        added;
        logic                        full;
    } node_result_t;

    typedef struct packed {
        logic [bdd_ut_pkg::VAR_W-1:0]   v;
        logic [bdd_ut_pkg::CHILD_W-1:0] h;
        logic [bdd_ut_pkg::CHILD_W-1:0] l;
    } triple_t;

    typedef struct {
        triple_t      trip;
        bit           typed;
        node_result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [bdd_ut_pkg::VAR_W-1:0]   var_index;
    logic [bdd_ut_pkg::CHILD_W-1:0] high_child;
    logic [bdd_ut_pkg::CHILD_W-1:0] low_child;
    logic                           done;
    logic [bdd_ut_pkg::ID_W-1:0]    node_id;
    logic                           was_added;
    logic                           table_full;

    // shadow copy of the node table
    logic [bdd_ut_pkg::VAR_W-1:0]   shadow_var  [bdd_ut_pkg::NODE_CAPACITY];
    logic [bdd_ut_pkg::CHILD_W-1:0] shadow_high [bdd_ut_pkg::NODE_CAPACITY];
    logic [bdd_ut_pkg::CHILD_W-1:0] shadow_low  [bdd_ut_pkg::NODE_CAPACITY];
    int                             node_count;

    node_result_t pending_results[$];
    triple_t      stored_triples[$];
    int           fail_count;
    bit           no_gaps;
    dir_row_t     dir_rows[DIR_ROWS];

    bdd_unique_node_table_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .var_index  (var_index),
        .high_child (high_child),
        .low_child  (low_child),
        .done       (done),
        .node_id    (node_id),
        .was_added  (was_added),
        .table_full (table_full)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // lowest stored id holding the triple, -1 if absent
    function automatic int find_node(triple_t t);
        for (int i = 0; i < node_count; i++)
        begin
            if (shadow_var[i] == t.v && shadow_high[i] == t.h && shadow_low[i] == t.l)
                return i;
        end
        return -1;
    endfunction

    // find-or-add on the shadow table
    function automatic node_result_t find_or_add(triple_t t);
        node_result_t r;
        int           hit;
        r = '0;
        if (int'(t.v) >= bdd_ut_pkg::VAR_COUNT)
            return r;
        // reduced node: equal children on a non-terminal variable
        if (t.v != bdd_ut_pkg::TERM_ZERO_VAR && t.v != bdd_ut_pkg::TERM_ONE_VAR &&
            t.h == t.l)
        begin
            r.id = t.h[bdd_ut_pkg::ID_W-1:0];
            return r;
        end
        hit = find_node(t);
        if (hit >= 0)
        begin
            r.id = bdd_ut_pkg::ID_W'(hit);
            return r;
        end
        if (node_count >= bdd_ut_pkg::NODE_CAPACITY)
        begin
            r.full = 1'b1;
            return r;
        end
        shadow_var[node_count]  = t.v;
        shadow_high[node_count] = t.h;
        shadow_low[node_count]  = t.l;
        stored_triples = {stored_triples, t};
        r.id    = bdd_ut_pkg::ID_W'(node_count);
        r.added = 1'b1;
        node_count++;
        return r;
    endfunction

    // hand one item over and record what it should give
    task automatic issue_node(input triple_t t, input bit typed, input node_result_t want);
        node_result_t got;
        start      <= 1'b1;
        var_index  <= t.v;
        high_child <= t.h;
        low_child  <= t.l;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        got = find_or_add(t);
        pending_results = {pending_results, (typed ? want : got)};
        // random idle gap on the sending side
        if (!no_gaps && $urandom_range(99) < 19)
        begin
            start      <= 1'b0;
            var_index  <= bdd_ut_pkg::VAR_W'($urandom);
            high_child <= bdd_ut_pkg::CHILD_W'($urandom);
            low_child  <= bdd_ut_pkg::CHILD_W'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // hold off until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [bdd_ut_pkg::CHILD_W-1:0] pick_child();
        int c;
        c = $urandom_range(99);
        if (c < 80)
            return bdd_ut_pkg::CHILD_W'($urandom_range(0, node_count - 1));
        else if (c < 90)
            return bdd_ut_pkg::NULL_CHILD;
        else
            return bdd_ut_pkg::CHILD_W'($urandom_range(1025, 2047));
    endfunction

    // new nodes over mostly existing ids, repeats, reduced and terminal-variable items, and noise
    function automatic triple_t random_triple();
        triple_t t;
        int      c;
        c = $urandom_range(99);
        if (c < 35)
        begin
            t.v = bdd_ut_pkg::VAR_W'($urandom_range(2, 255));
            t.h = pick_child();
            t.l = pick_child();
        end
        else if (c < 60)
            t = stored_triples[$urandom_range(0, stored_triples.size() - 1)];
        else if (c < 70)
        begin
            t.v = bdd_ut_pkg::VAR_W'($urandom_range(2, 255));
            t.h = bdd_ut_pkg::CHILD_W'($urandom_range(0, 2047));
            t.l = t.h;
        end
        else if (c < 80)
        begin
            t.v = bdd_ut_pkg::VAR_W'($urandom_range(0, 1));
            t.h = pick_child();
            t.l = pick_child();
        end
        else
        begin
            t.v = bdd_ut_pkg::VAR_W'($urandom);
            t.h = bdd_ut_pkg::CHILD_W'($urandom);
            t.l = bdd_ut_pkg::CHILD_W'($urandom);
        end
        return t;
    endfunction

    // result check against the oldest outstanding item
    always @(posedge clk)
    begin : result_check
        node_result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item waiting: node_id %0d", node_id);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (node_id !== exp_r.id)
                begin
                    $error("node_id: expected %0d, got %0d", exp_r.id, node_id);
                    fail_count++;
                end
                if (was_added !== exp_r.added)
                begin
                    $error("was_added: expected %0d, got %0d", exp_r.added, was_added);
                    fail_count++;
                end
                if (table_full !== exp_r.full)
                begin
                    $error("table_full: expected %0d, got %0d", exp_r.full, table_full);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        node_result_t none;
        none       = '0;
        fail_count = 0;
        no_gaps    = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        var_index  = '0;
        high_child = '0;
        low_child  = '0;

        // terminals preloaded in the shadow table
        shadow_var[0]  = bdd_ut_pkg::TERM_ZERO_VAR;
        shadow_high[0] = bdd_ut_pkg::NULL_CHILD;
        shadow_low[0]  = bdd_ut_pkg::NULL_CHILD;
        shadow_var[1]  = bdd_ut_pkg::TERM_ONE_VAR;
        shadow_high[1] = bdd_ut_pkg::NULL_CHILD;
        shadow_low[1]  = bdd_ut_pkg::NULL_CHILD;
        node_count     = 2;
        stored_triples = {stored_triples,
                          triple_t'{bdd_ut_pkg::TERM_ZERO_VAR, bdd_ut_pkg::NULL_CHILD,
                                    bdd_ut_pkg::NULL_CHILD}};
        stored_triples = {stored_triples,
                          triple_t'{bdd_ut_pkg::TERM_ONE_VAR, bdd_ut_pkg::NULL_CHILD,
                                    bdd_ut_pkg::NULL_CHILD}};

        // directed items: terminals, reduction, appends, hits, raw child codes
        dir_rows = '{
            '{'{8'd0,   11'd1024, 11'd1024}, 1'b1, '{10'd0,    1'b0, 1'b0}},
            '{'{8'd1,   11'd1024, 11'd1024}, 1'b1, '{10'd1,    1'b0, 1'b0}},
            '{'{8'd5,   11'd7,    11'd7},    1'b1, '{10'd7,    1'b0, 1'b0}},
            '{'{8'd255, 11'd1024, 11'd1024}, 1'b1, '{10'd0,    1'b0, 1'b0}},
            '{'{8'd200, 11'd2047, 11'd2047}, 1'b1, '{10'd1023, 1'b0, 1'b0}},
            '{'{8'd2,   11'd1,    11'd0},    1'b1, '{10'd2,    1'b1, 1'b0}},
            '{'{8'd2,   11'd1,    11'd0},    1'b1, '{10'd2,    1'b0, 1'b0}},
            '{'{8'd3,   11'd2,    11'd0},    1'b0, none},
            '{'{8'd0,   11'd1,    11'd0},    1'b0, none},
            '{'{8'd1,   11'd5,    11'd5},    1'b0, none},
            '{'{8'd0,   11'd1024, 11'd1024}, 1'b1, '{10'd0,    1'b0, 1'b0}},
            '{'{8'd255, 11'd2047, 11'd0},    1'b0, none},
            '{'{8'd255, 11'd0,    11'd2047}, 1'b0, none},
            '{'{8'd128, 11'd1025, 11'd1024}, 1'b0, none},
            '{'{8'd128, 11'd1025, 11'd1024}, 1'b0, none},
            '{'{8'd255, 11'd2047, 11'd0},    1'b0, none},
            '{'{8'd4,   11'd1024, 11'd3},    1'b0, none},
            '{'{8'd0,   11'd0,    11'd0},    1'b0, none},
            '{'{8'd2,   11'd0,    11'd1},    1'b0, none},
            '{'{8'd255, 11'd1023, 11'd1023}, 1'b1, '{10'd1023, 1'b0, 1'b0}}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            issue_node(dir_rows[i].trip, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        // random mix, with one stretch of back-to-back items
        for (int n = 0; n < 680; n++)
        begin
            no_gaps = (n >= 300 && n < 420);
            issue_node(random_triple(), 1'b0, none);
            if (n % 150 == 149)
                drain_results();
        end
        no_gaps = 1'b0;

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
